FILE: sv/pacp_pkg.sv
// Shared types, constants and register codes of the PID angle-to-PWM controller.
package pacp_pkg;

  // Field widths
  localparam int unsigned ADC_W      = 12;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned TARGET_W   = 25;
  localparam int unsigned GAIN_W     = 31;
  localparam int unsigned DRIVE_W    = 32;
  localparam int unsigned PWM_W      = 10;
  localparam int unsigned INTEG_W    = 48;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Shared arithmetic widths
  localparam int unsigned MUL_W      = 32;
  localparam int unsigned PROD_W     = 2 * MUL_W;
  localparam int unsigned DIV_NUM_W  = 64;
  localparam int unsigned DIV_DEN_W  = 32;

  // Defaults of the top-level parameters
  localparam int unsigned ADC_FULL_SCALE_DEF = 4095;
  localparam int unsigned PWM_FULL_SCALE_DEF = 1000;

  // Fixed-point constants
  localparam int unsigned Q_ONE      = 65536;
  localparam int unsigned ANGLE_SPAN = 270;
  localparam int unsigned MS_PER_S   = 1000;

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_ANGLE = 3'd0,
    REG_GAIN_P       = 3'd1,
    REG_GAIN_I       = 3'd2,
    REG_GAIN_D       = 3'd3,
    REG_DRIVE_MAX    = 3'd4,
    REG_DRIVE_MIN    = 3'd5
  } pacp_reg_e;

  typedef struct packed {
    logic        [TARGET_W-1:0] target_angle;
    logic        [GAIN_W-1:0]   gain_p;
    logic        [GAIN_W-1:0]   gain_i;
    logic        [GAIN_W-1:0]   gain_d;
    logic signed [DRIVE_W-1:0]  drive_max;
    logic signed [DRIVE_W-1:0]  drive_min;
  } pacp_cfg_t;

  localparam pacp_cfg_t CFG_RST = '{
    target_angle: 25'd0,
    gain_p:       31'd3276800,
    gain_i:       31'd6554,
    gain_d:       31'd655360,
    drive_max:    32'sd196608,
    drive_min:    -32'sd196608
  };

  // Divider request and response
  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } pacp_div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [DIV_NUM_W-1:0] quot;
  } pacp_div_rsp_t;

endpackage

FILE: sv/pacp_cfg.sv
// Configuration register file of the PID angle-to-PWM controller.
module pacp_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pacp_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [pacp_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output pacp_pkg::pacp_cfg_t                 cfg_o
);

  pacp_pkg::pacp_cfg_t cfg_q, cfg_d;

  // Accept a write request in every cycle
  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // Decode the register index, drop writes to unknown indexes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (pacp_pkg::pacp_reg_e'(cfg_index_i))
        pacp_pkg::REG_TARGET_ANGLE: cfg_d.target_angle = cfg_data_i[pacp_pkg::TARGET_W-1:0];
        pacp_pkg::REG_GAIN_P:       cfg_d.gain_p       = cfg_data_i[pacp_pkg::GAIN_W-1:0];
        pacp_pkg::REG_GAIN_I:       cfg_d.gain_i       = cfg_data_i[pacp_pkg::GAIN_W-1:0];
        pacp_pkg::REG_GAIN_D:       cfg_d.gain_d       = cfg_data_i[pacp_pkg::GAIN_W-1:0];
        pacp_pkg::REG_DRIVE_MAX:    cfg_d.drive_max    = $signed(cfg_data_i);
        pacp_pkg::REG_DRIVE_MIN:    cfg_d.drive_min    = $signed(cfg_data_i);
        default:                    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= pacp_pkg::CFG_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

FILE: sv/pacp_mul.sv
// Shared registered 32x32 unsigned multiplier of the PID angle-to-PWM controller.
module pacp_mul (
  input  logic                          clk_i,
  input  logic [pacp_pkg::MUL_W-1:0]    a_i,
  input  logic [pacp_pkg::MUL_W-1:0]    b_i,
  output logic [pacp_pkg::PROD_W-1:0]   prod_o
);

  logic [pacp_pkg::PROD_W-1:0] prod_q;

  // Register the product every cycle
  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;

endmodule

FILE: sv/pacp_div.sv
// Shared radix-4 restoring divider of the PID angle-to-PWM controller.
module pacp_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  pacp_pkg::pacp_div_req_t req_i,
  output pacp_pkg::pacp_div_rsp_t rsp_o
);

  localparam int unsigned NumW  = pacp_pkg::DIV_NUM_W;
  localparam int unsigned DenW  = pacp_pkg::DIV_DEN_W;
  localparam int unsigned Steps = NumW / 2;
  localparam int unsigned CntW  = $clog2(Steps);

  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW-1:0] rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;

  logic [DenW:0]   try1, try2;
  logic [DenW-1:0] rem1, rem2;
  logic            bit1, bit2;

  // Two restoring steps per cycle
  always_comb begin
    try1 = {rem_q, quo_q[NumW-1]};
    bit1 = (try1 >= {1'b0, den_q});
    rem1 = bit1 ? DenW'(try1 - {1'b0, den_q}) : try1[DenW-1:0];
    try2 = {rem1, quo_q[NumW-2]};
    bit2 = (try2 >= {1'b0, den_q});
    rem2 = bit2 ? DenW'(try2 - {1'b0, den_q}) : try2[DenW-1:0];
  end

  // Load on start, shift quotient bits in while busy, flag the last step
  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      quo_d  = req_i.num;
      rem_d  = '0;
      den_d  = req_i.den;
      cnt_d  = CntW'(Steps - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[NumW-3:0], bit1, bit2};
      rem_d = rem2;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

endmodule

FILE: sv/pid_angle_to_pwm_controller.sv
// Top level of the PID angle-to-PWM controller: sequencer, datapath and state.
//
// Takes one 12-bit angle sample with its millisecond timestamp per request and returns one
// result: the clamped PID drive level (signed Q16.16) and the PWM compare value. The
// block works on one request at a time; in_ready_o is high only while it waits for a new
// sample. The derivative divide is skipped when the timestamp has not advanced. A request
// makes up to four passes through the shared divider, which resolves two quotient bits per
// cycle over a 64-bit numerator, plus six passes through the shared 32x32 multiplier for
// the gain products. A finished result waits in the output register while the next sample
// is already being processed. Configuration writes are taken in every cycle and must only
// happen while no request is in flight.
module pid_angle_to_pwm_controller #(
  parameter int unsigned ADC_FULL_SCALE = pacp_pkg::ADC_FULL_SCALE_DEF,
  parameter int unsigned PWM_FULL_SCALE = pacp_pkg::PWM_FULL_SCALE_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [pacp_pkg::ADC_W-1:0]           adc_sample_i,
  input  logic [pacp_pkg::TIME_W-1:0]          time_ms_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [pacp_pkg::DRIVE_W-1:0]  drive_level_o,
  output logic [pacp_pkg::PWM_W-1:0]           pwm_compare_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [pacp_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [pacp_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int unsigned AdcHalf    = ADC_FULL_SCALE / 2;
  localparam int unsigned PwmDen     = 6 * pacp_pkg::Q_ONE;
  localparam int unsigned DriveOfs   = 3 * pacp_pkg::Q_ONE;
  localparam int unsigned MsHalf     = pacp_pkg::MS_PER_S / 2;
  localparam int unsigned RoundHalf  = pacp_pkg::Q_ONE / 2;
  localparam int unsigned AngleW     = 29;
  localparam int unsigned IncW       = 53;
  localparam int unsigned DerivW     = 42;
  localparam int unsigned MagW       = 48;
  localparam int unsigned TermW      = 61;
  localparam int unsigned SumW       = 63;
  localparam int unsigned VW         = 19;
  localparam logic [63:0] TermLimit  = 64'd1 << 60;

  typedef enum logic [19:0] {
    S_IDLE     = 20'h00001,
    S_ANG_MUL  = 20'h00002,
    S_ANG_DIV  = 20'h00004,
    S_ANG_WAIT = 20'h00008,
    S_INT_MUL  = 20'h00010,
    S_INT_DIV  = 20'h00020,
    S_INT_WAIT = 20'h00040,
    S_DER_MUL  = 20'h00080,
    S_DER_DIV  = 20'h00100,
    S_DER_WAIT = 20'h00200,
    S_P_SEL    = 20'h00400,
    S_P_LO     = 20'h00800,
    S_P_HI     = 20'h01000,
    S_P_ACC    = 20'h02000,
    S_P_SUM    = 20'h04000,
    S_CLAMP    = 20'h08000,
    S_PWM_MUL  = 20'h10000,
    S_PWM_DIV  = 20'h20000,
    S_PWM_WAIT = 20'h40000,
    S_FIN      = 20'h80000
  } state_e;

  typedef enum logic [1:0] {
    TERM_P = 2'd0,
    TERM_I = 2'd1,
    TERM_D = 2'd2
  } term_e;

  state_e state_q, state_d;
  term_e  term_sel_q, term_sel_d;

  pacp_pkg::pacp_cfg_t      cfg;
  pacp_pkg::pacp_div_req_t  div_req;
  pacp_pkg::pacp_div_rsp_t  div_rsp;

  logic [pacp_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic [pacp_pkg::PROD_W-1:0] mul_prod;

  // Loop state
  logic [pacp_pkg::TIME_W-1:0]          prev_time_q, prev_time_d;
  logic signed [pacp_pkg::DRIVE_W-1:0]  prev_error_q, prev_error_d;
  logic signed [pacp_pkg::INTEG_W-1:0]  integ_q, integ_d;

  // Per-request working registers
  logic [pacp_pkg::ADC_W-1:0]           adc_q, adc_d;
  logic [pacp_pkg::TIME_W-1:0]          dt_q, dt_d;
  logic signed [pacp_pkg::DRIVE_W-1:0]  error_q, error_d;
  logic                                 diff_neg_q, diff_neg_d;
  logic signed [DerivW-1:0]             deriv_q, deriv_d;
  logic [MagW-1:0]                      mag_q, mag_d;
  logic                                 neg_q, neg_d;
  logic [39:0]                          lo_q, lo_d;
  logic [TermW-1:0]                     term_mag_q, term_mag_d;
  logic signed [SumW-1:0]               sum_q, sum_d;
  logic signed [pacp_pkg::DRIVE_W-1:0]  drive_q, drive_d;

  // Output register
  logic                                 out_valid_q, out_valid_d;
  logic signed [pacp_pkg::DRIVE_W-1:0]  out_drive_q, out_drive_d;
  logic [pacp_pkg::PWM_W-1:0]           out_pwm_q, out_pwm_d;

  // Datapath helpers
  logic signed [pacp_pkg::DRIVE_W-1:0]  error_new;
  logic [pacp_pkg::DRIVE_W-1:0]         err_mag;
  logic signed [32:0]                   diff;
  logic [32:0]                          diff_mag;
  logic signed [IncW:0]                 inc;
  logic signed [IncW:0]                 integ_sum;
  logic [MagW-1:0]                      integ_mag;
  logic [DerivW-1:0]                    deriv_mag;
  logic [pacp_pkg::GAIN_W-1:0]          gain_sel;
  logic [pacp_pkg::PROD_W-1:0]          lo_round;
  logic [63:0]                          term_raw;
  logic signed [SumW-1:0]               term_signed;
  logic signed [SumW-1:0]               dmax_ext, dmin_ext;
  logic signed [32:0]                   v_ofs;
  logic [VW-1:0]                        v_clamped;

  pacp_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  pacp_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (mul_prod)
  );

  pacp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Signed and magnitude forms of the loop quantities
  always_comb begin
    error_new = $signed({7'b0, cfg.target_angle}) - $signed({3'b0, div_rsp.quot[AngleW-1:0]});
    err_mag   = error_q[31] ? (~error_q + 1'b1) : error_q;
    diff      = $signed({error_q[31], error_q}) - $signed({prev_error_q[31], prev_error_q});
    diff_mag  = diff[32] ? (~diff + 1'b1) : diff;
    inc       = error_q[31] ? -$signed({1'b0, div_rsp.quot[IncW-1:0]})
                            : $signed({1'b0, div_rsp.quot[IncW-1:0]});
    integ_sum = $signed({{(IncW + 1 - pacp_pkg::INTEG_W){integ_q[47]}}, integ_q}) + inc;
    integ_mag = integ_q[47] ? (~integ_q + 1'b1) : integ_q;
    deriv_mag = deriv_q[DerivW-1] ? (~deriv_q + 1'b1) : deriv_q;
    lo_round  = mul_prod + pacp_pkg::PROD_W'(RoundHalf);
    term_raw  = {mul_prod[55:0], 8'b0} + {24'b0, lo_q};
    term_signed = neg_q ? -$signed({2'b0, term_mag_q}) : $signed({2'b0, term_mag_q});
    dmax_ext  = $signed({{(SumW - pacp_pkg::DRIVE_W){cfg.drive_max[31]}}, cfg.drive_max});
    dmin_ext  = $signed({{(SumW - pacp_pkg::DRIVE_W){cfg.drive_min[31]}}, cfg.drive_min});
    v_ofs     = $signed({drive_q[31], drive_q}) + $signed(33'(DriveOfs));
    if (v_ofs[32]) begin
      v_clamped = '0;
    end else if (v_ofs > $signed(33'(PwmDen))) begin
      v_clamped = VW'(PwmDen);
    end else begin
      v_clamped = v_ofs[VW-1:0];
    end
  end

  // Pick the gain of the current PID term
  always_comb begin
    case (term_sel_q)
      TERM_P:  gain_sel = cfg.gain_p;
      TERM_I:  gain_sel = cfg.gain_i;
      TERM_D:  gain_sel = cfg.gain_d;
      default: gain_sel = '0;
    endcase
  end

  // Steer the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_ANG_MUL: begin
        mul_a = {20'b0, adc_q};
        mul_b = 32'(pacp_pkg::ANGLE_SPAN);
      end
      S_INT_MUL: begin
        mul_a = err_mag;
        mul_b = dt_q;
      end
      S_DER_MUL: begin
        mul_a = diff_mag[31:0];
        mul_b = 32'(pacp_pkg::MS_PER_S);
      end
      S_P_LO: begin
        mul_a = {1'b0, gain_sel};
        mul_b = {8'b0, mag_q[23:0]};
      end
      S_P_HI: begin
        mul_a = {1'b0, gain_sel};
        mul_b = {8'b0, mag_q[47:24]};
      end
      S_PWM_MUL: begin
        mul_a = {13'b0, v_clamped};
        mul_b = 32'(PWM_FULL_SCALE);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Steer the shared divider
  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = mul_prod;
    div_req.den   = 32'(pacp_pkg::MS_PER_S);
    case (state_q)
      S_ANG_DIV: begin
        div_req.start = 1'b1;
        div_req.num   = {mul_prod[47:0], 16'b0} + 64'(AdcHalf);
        div_req.den   = 32'(ADC_FULL_SCALE);
      end
      S_INT_DIV: begin
        div_req.start = 1'b1;
        div_req.num   = mul_prod + 64'(MsHalf);
      end
      S_DER_DIV: begin
        div_req.start = (dt_q != '0);
        div_req.num   = mul_prod + {33'b0, dt_q[31:1]};
        div_req.den   = dt_q;
      end
      S_PWM_DIV: begin
        div_req.start = 1'b1;
        div_req.den   = 32'(PwmDen);
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  // Sequencer and register updates
  always_comb begin
    state_d      = state_q;
    term_sel_d   = term_sel_q;
    prev_time_d  = prev_time_q;
    prev_error_d = prev_error_q;
    integ_d      = integ_q;
    adc_d        = adc_q;
    dt_d         = dt_q;
    error_d      = error_q;
    diff_neg_d   = diff_neg_q;
    deriv_d      = deriv_q;
    mag_d        = mag_q;
    neg_d        = neg_q;
    lo_d         = lo_q;
    term_mag_d   = term_mag_q;
    sum_d        = sum_q;
    drive_d      = drive_q;
    out_valid_d  = out_valid_q;
    out_drive_d  = out_drive_q;
    out_pwm_d    = out_pwm_q;

    // Drop the result once it is taken
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          adc_d       = adc_sample_i;
          dt_d        = time_ms_i - prev_time_q;
          prev_time_d = time_ms_i;
          sum_d       = '0;
          term_sel_d  = TERM_P;
          state_d     = S_ANG_MUL;
        end
      end
      S_ANG_MUL:  state_d = S_ANG_DIV;
      S_ANG_DIV:  state_d = S_ANG_WAIT;
      S_ANG_WAIT: begin
        if (div_rsp.done) begin
          error_d = error_new;
          state_d = S_INT_MUL;
        end
      end
      S_INT_MUL:  state_d = S_INT_DIV;
      S_INT_DIV:  state_d = S_INT_WAIT;
      S_INT_WAIT: begin
        if (div_rsp.done) begin
          // Saturate the integral to its 48-bit range
          if ((integ_sum[IncW:47] == '0) || (integ_sum[IncW:47] == '1)) begin
            integ_d = integ_sum[47:0];
          end else if (!integ_sum[IncW]) begin
            integ_d = {1'b0, {47{1'b1}}};
          end else begin
            integ_d = {1'b1, 47'b0};
          end
          state_d = S_DER_MUL;
        end
      end
      S_DER_MUL: begin
        diff_neg_d   = diff[32];
        prev_error_d = error_q;
        state_d      = S_DER_DIV;
      end
      S_DER_DIV: begin
        if (dt_q == '0) begin
          deriv_d = '0;
          state_d = S_P_SEL;
        end else begin
          state_d = S_DER_WAIT;
        end
      end
      S_DER_WAIT: begin
        if (div_rsp.done) begin
          deriv_d = diff_neg_q ? -$signed({1'b0, div_rsp.quot[DerivW-2:0]})
                               : $signed({1'b0, div_rsp.quot[DerivW-2:0]});
          state_d = S_P_SEL;
        end
      end
      S_P_SEL: begin
        case (term_sel_q)
          TERM_P: begin
            mag_d = {16'b0, err_mag};
            neg_d = error_q[31];
          end
          TERM_I: begin
            mag_d = integ_mag;
            neg_d = integ_q[47];
          end
          TERM_D: begin
            mag_d = {6'b0, deriv_mag};
            neg_d = deriv_q[DerivW-1];
          end
          default: begin
            mag_d = '0;
            neg_d = 1'b0;
          end
        endcase
        state_d = S_P_LO;
      end
      S_P_LO:     state_d = S_P_HI;
      S_P_HI: begin
        lo_d    = lo_round[55:16];
        state_d = S_P_ACC;
      end
      S_P_ACC: begin
        term_mag_d = (term_raw > TermLimit) ? TermLimit[TermW-1:0] : term_raw[TermW-1:0];
        state_d    = S_P_SUM;
      end
      S_P_SUM: begin
        sum_d = sum_q + term_signed;
        case (term_sel_q)
          TERM_P: begin
            term_sel_d = TERM_I;
            state_d    = S_P_SEL;
          end
          TERM_I: begin
            term_sel_d = TERM_D;
            state_d    = S_P_SEL;
          end
          default: begin
            state_d = S_CLAMP;
          end
        endcase
      end
      S_CLAMP: begin
        if (sum_q > dmax_ext) begin
          drive_d = cfg.drive_max;
        end else if (sum_q < dmin_ext) begin
          drive_d = cfg.drive_min;
        end else begin
          drive_d = sum_q[31:0];
        end
        state_d = S_PWM_MUL;
      end
      S_PWM_MUL:  state_d = S_PWM_DIV;
      S_PWM_DIV:  state_d = S_PWM_WAIT;
      S_PWM_WAIT: begin
        if (div_rsp.done) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        // Hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_drive_d = drive_q;
          out_pwm_d   = div_rsp.quot[pacp_pkg::PWM_W-1:0];
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      term_sel_q   <= TERM_P;
      prev_time_q  <= '0;
      prev_error_q <= '0;
      integ_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      term_sel_q   <= term_sel_d;
      prev_time_q  <= prev_time_d;
      prev_error_q <= prev_error_d;
      integ_q      <= integ_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    adc_q       <= adc_d;
    dt_q        <= dt_d;
    error_q     <= error_d;
    diff_neg_q  <= diff_neg_d;
    deriv_q     <= deriv_d;
    mag_q       <= mag_d;
    neg_q       <= neg_d;
    lo_q        <= lo_d;
    term_mag_q  <= term_mag_d;
    sum_q       <= sum_d;
    drive_q     <= drive_d;
    out_drive_q <= out_drive_d;
    out_pwm_q   <= out_pwm_d;
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign drive_level_o = out_drive_q;
  assign pwm_compare_o = out_pwm_q;

`ifndef NO_ASSERTIONS
  // A new divide never starts on top of a running one
  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  // A new sample is only taken with the divider at rest
  a_ready_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !div_rsp.busy && !div_rsp.done)
    else $error("ready while a divide is in flight");

  // The drive stays inside ordered limits
  a_drive_in_limits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (cfg.drive_min <= cfg.drive_max)
    |-> (drive_level_o <= cfg.drive_max) && (drive_level_o >= cfg.drive_min))
    else $error("drive level outside clamp limits");

  // The compare value never exceeds full scale
  a_pwm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (PWM_FULL_SCALE < 1024)
    |-> ({6'b0, pwm_compare_o} <= 16'(PWM_FULL_SCALE)))
    else $error("pwm compare above full scale");
`endif

endmodule
